FILE: hdl/ccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants for the conveyor color sorter controller.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int unsigned ColourW = 14;
  localparam int unsigned DistW   = 8;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam logic [ColourW-1:0] MinStart        = ColourW'(10000);
  localparam logic [ColourW-1:0] WhiteLimitRst   = ColourW'(2500);
  localparam logic [ColourW-1:0] RedLimitRst     = ColourW'(4600);
  localparam logic [DistW-1:0]   WhiteDistRst    = DistW'(3);
  localparam logic [DistW-1:0]   RedDistRst      = DistW'(9);
  localparam logic [DistW-1:0]   BlueDistRst     = DistW'(15);
  localparam logic [TicksW-1:0]  EjectTicksRst   = TicksW'(1500);
  localparam logic [DistW-1:0]   StepMax         = {DistW{1'b1}};

  // Controller states, encoded as the phase field reports them
  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_SENSE = 2'd1,
    PH_MOVE  = 2'd2,
    PH_EJECT = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    COL_WHITE = 2'd0,
    COL_RED   = 2'd1,
    COL_BLUE  = 2'd2,
    COL_SPARE = 2'd3
  } colour_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WHITE_LIMIT = 3'd0,
    CFG_RED_LIMIT   = 3'd1,
    CFG_WHITE_DIST  = 3'd2,
    CFG_RED_DIST    = 3'd3,
    CFG_BLUE_DIST   = 3'd4,
    CFG_EJECT_TICKS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ColourW-1:0] white_limit;
    logic [ColourW-1:0] red_limit;
    logic [DistW-1:0]   white_distance;
    logic [DistW-1:0]   red_distance;
    logic [DistW-1:0]   blue_distance;
    logic [TicksW-1:0]  eject_ticks;
  } cfg_t;

  typedef struct packed {
    logic               entry_beam;
    logic               exit_beam;
    logic               pulse_level;
    logic [ColourW-1:0] colour_sample;
  } in_word_t;

  typedef struct packed {
    logic       conveyor_on;
    logic       compressor_on;
    logic       eject_white;
    logic       eject_red;
    logic       eject_blue;
    logic [1:0] phase;
  } out_word_t;

endpackage

FILE: hdl/ccs_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_cfg_regs
// Configuration register file: thresholds, travel distances, eject length.
// ----------------------------------------------------------------------------
module ccs_cfg_regs
  import ccs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  // Write the addressed register, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.white_limit    <= WhiteLimitRst;
      cfg_q.red_limit      <= RedLimitRst;
      cfg_q.white_distance <= WhiteDistRst;
      cfg_q.red_distance   <= RedDistRst;
      cfg_q.blue_distance  <= BlueDistRst;
      cfg_q.eject_ticks    <= EjectTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WHITE_LIMIT: cfg_q.white_limit    <= cfg_data_i[ColourW-1:0];
        CFG_RED_LIMIT:   cfg_q.red_limit      <= cfg_data_i[ColourW-1:0];
        CFG_WHITE_DIST:  cfg_q.white_distance <= cfg_data_i[DistW-1:0];
        CFG_RED_DIST:    cfg_q.red_distance   <= cfg_data_i[DistW-1:0];
        CFG_BLUE_DIST:   cfg_q.blue_distance  <= cfg_data_i[DistW-1:0];
        CFG_EJECT_TICKS: cfg_q.eject_ticks    <= cfg_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/ccs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_core
// Sorter state machine: one tick per enable, result taken from the next state.
// ----------------------------------------------------------------------------
module ccs_core
  import ccs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  word_i,
  input  cfg_t      cfg_i,
  output out_word_t result_o
);

  phase_e              phase_q, phase_d;
  logic [ColourW-1:0]  min_q, min_d;
  logic [DistW-1:0]    target_q, target_d;
  logic [DistW-1:0]    moved_q, moved_d;
  logic                last_pulse_q, last_pulse_d;
  colour_e             colour_q, colour_d;
  logic [TicksW-1:0]   timer_q, timer_d;
  logic                conveyor_q, conveyor_d;
  logic                compressor_q, compressor_d;
  logic [ColourW-1:0]  min_now;
  logic [DistW-1:0]    moved_now;
  logic                ejecting;

  // Hold state between ticks, advance on each processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WAIT;
      min_q        <= MinStart;
      target_q     <= '0;
      moved_q      <= '0;
      last_pulse_q <= 1'b0;
      colour_q     <= COL_BLUE;
      timer_q      <= '0;
      conveyor_q   <= 1'b0;
      compressor_q <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      min_q        <= min_d;
      target_q     <= target_d;
      moved_q      <= moved_d;
      last_pulse_q <= last_pulse_d;
      colour_q     <= colour_d;
      timer_q      <= timer_d;
      conveyor_q   <= conveyor_d;
      compressor_q <= compressor_d;
    end
  end

  // Next state for one tick
  always_comb begin
    phase_d      = phase_q;
    min_d        = min_q;
    target_d     = target_q;
    moved_d      = moved_q;
    last_pulse_d = last_pulse_q;
    colour_d     = colour_q;
    timer_d      = timer_q;
    conveyor_d   = conveyor_q;
    compressor_d = compressor_q;

    min_now   = (word_i.colour_sample < min_q) ? word_i.colour_sample : min_q;
    moved_now = (word_i.pulse_level && !last_pulse_q && (moved_q != StepMax))
                ? moved_q + DistW'(1) : moved_q;

    unique case (phase_q)
      PH_WAIT: begin
        if (!word_i.entry_beam) begin
          phase_d    = PH_SENSE;
          conveyor_d = 1'b1;
          min_d      = MinStart;
        end
      end
      PH_SENSE: begin
        min_d = min_now;
        if (!word_i.exit_beam) begin
          phase_d      = PH_MOVE;
          moved_d      = '0;
          compressor_d = 1'b1;
          // Classify on the minimum including this tick's sample
          if (min_now < cfg_i.white_limit) begin
            target_d = cfg_i.white_distance;
            colour_d = COL_WHITE;
          end else if (min_now < cfg_i.red_limit) begin
            target_d = cfg_i.red_distance;
            colour_d = COL_RED;
          end else begin
            target_d = cfg_i.blue_distance;
            colour_d = COL_BLUE;
          end
        end
      end
      PH_MOVE: begin
        moved_d      = moved_now;
        last_pulse_d = word_i.pulse_level;
        if (moved_now >= target_q) begin
          phase_d    = PH_EJECT;
          conveyor_d = 1'b0;
          timer_d    = TicksW'(1);
        end
      end
      PH_EJECT: begin
        if (timer_q >= cfg_i.eject_ticks) begin
          phase_d = PH_WAIT;
          timer_d = '0;
        end else begin
          timer_d = timer_q + TicksW'(1);
        end
      end
      default: ;
    endcase
  end

  // Result reflects the state after this tick
  assign ejecting = (phase_d == PH_EJECT);

  always_comb begin
    result_o.conveyor_on   = conveyor_d;
    result_o.compressor_on = compressor_d;
    result_o.eject_white   = ejecting && (colour_d == COL_WHITE);
    result_o.eject_red     = ejecting && (colour_d == COL_RED);
    result_o.eject_blue    = ejecting && (colour_d != COL_WHITE) && (colour_d != COL_RED);
    result_o.phase         = phase_d;
  end

endmodule

FILE: hdl/conveyor_color_sorter_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conveyor_color_sorter_controller_unit
// Color-sorting conveyor controller, one sample tick per input word.
// ----------------------------------------------------------------------------
// Each input word is one sample tick of the entry and exit barriers, the pulse
// key and the color reading; each tick yields exactly one output word with the
// drive levels and phase after that tick. The block takes one word per clock
// while the output is not stalled: a word is held in the input register, the
// state machine computes its next state from it combinationally, and the result
// lands in the output register, where it is held while out_stall_i is high;
// throughput is one word per cycle without output stalls. Configuration writes
// take effect on the next clock and should be made while no word is in flight.
module conveyor_color_sorter_controller_unit
  import ccs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_word_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_word_t          out_word_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cfg_t      cfg;
  out_word_t result;
  logic      in_vld_q;
  in_word_t  in_word_q;
  logic      out_vld_q;
  out_word_t out_word_q;
  logic      advance;

  ccs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Move the held word into the result register when that register frees up
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  ccs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .word_i   (in_word_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: hdl/ccs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks for the sorter controller, bound to the top level.
// ----------------------------------------------------------------------------
module ccs_checker
  import ccs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // Hold a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // At most one ejector, and only while ejecting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_word_o.eject_white, out_word_o.eject_red,
                              out_word_o.eject_blue}))
    else $error("more than one ejector driven");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.eject_white || out_word_o.eject_red ||
                    out_word_o.eject_blue) |-> out_word_o.phase == PH_EJECT)
    else $error("ejector driven outside eject phase");

  // Conveyor runs exactly while sensing or moving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.conveyor_on ==
      (out_word_o.phase == PH_SENSE || out_word_o.phase == PH_MOVE))
    else $error("conveyor drive does not match phase");

  // Compressor is latched once a part has been classified
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.phase == PH_MOVE || out_word_o.phase == PH_EJECT)
      |-> out_word_o.compressor_on)
    else $error("compressor off after classification");

endmodule

bind conveyor_color_sorter_controller_unit ccs_checker u_ccs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
